// ===== design/assert_macros.svh =====
// Assertion macros shared by the line stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bsl_pkg.sv =====
// Package with shared types, codes and constants of the line stepper.
package bsl_pkg;

    localparam int COORD_BITS_DEFAULT = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        STYLE_SOLID   = 2'd0,
        STYLE_DOTTED  = 2'd1,
        STYLE_DASHED  = 2'd2,
        STYLE_DASHDOT = 2'd3
    } style_t;

    localparam logic [1:0] MOD3_LAST    = 2'd2;
    localparam logic [2:0] MOD5_LAST    = 3'd4;
    localparam logic [3:0] DASHDOT_LAST = 4'd9;
    localparam logic [3:0] DASHDOT_GAP  = 4'd2;

    typedef struct packed {
        logic take;
        logic opcode;
    } step_ctrl_t;

    typedef struct packed {
        logic plot;
        logic last;
        logic valid_res;
    } pixel_flags_t;

    function automatic logic style_plots(input style_t style, input logic [1:0] mod3,
                                         input logic [2:0] mod5, input logic [3:0] phase);
        logic result;
        case (style)
            STYLE_SOLID:   result = 1'b1;
            STYLE_DOTTED:  result = (mod3 == 2'd0);
            STYLE_DASHED:  result = (mod5 != 3'd0);
            default:       result = (phase != 4'd0) && (phase != DASHDOT_GAP)
                                    && (phase <= DASHDOT_LAST);
        endcase
        return result;
    endfunction

endpackage

// ===== design/bsl_if.sv =====
// Valid/ready channel interfaces for the stepper commands and pixels.
interface bsl_in_if #(parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEFAULT) ();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bsl_out_if #(parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEFAULT) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  plot;
    logic                  last;
    logic                  valid_res;

    modport source (output valid, pixel_x, pixel_y, plot, last, valid_res, input ready);
    modport sink (input valid, pixel_x, pixel_y, plot, last, valid_res, output ready);
endinterface

// ===== design/bsl_stepper.sv =====
// Line state registers and the per-beat load and step datapath.
module bsl_stepper #(
    parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bsl_pkg::step_ctrl_t     ctrl,
    input  bsl_pkg::style_t         style,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    output logic [COORD_BITS-1:0]   pix_x,
    output logic [COORD_BITS-1:0]   pix_y,
    output bsl_pkg::pixel_flags_t   flags
);

    localparam int ERR_BITS = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      major_end_reg, major_end_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [COORD_BITS-1:0]      abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0]      abs_dy_reg, abs_dy_next;
    logic                       x_major_reg, x_major_next;
    logic                       minor_down_reg, minor_down_next;
    logic [1:0]                 mod3_reg, mod3_next;
    logic [2:0]                 mod5_reg, mod5_next;
    logic [3:0]                 phase_reg, phase_next;
    logic                       active_reg, active_next;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      ld_adx, ld_ady;
    logic                       ld_x_major, ld_fwd;
    logic [COORD_BITS-1:0]      ld_x, ld_y, ld_end;
    logic                       ld_active;
    logic                       st_keep;
    logic signed [ERR_BITS-1:0] st_inc_keep, st_inc_move;
    logic [COORD_BITS-1:0]      st_x, st_y, st_major;

    always_comb
    begin
        dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        ld_adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ld_ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        ld_x_major = (ld_ady <= ld_adx);
        ld_fwd = ld_x_major ? !dx[COORD_BITS] : !dy[COORD_BITS];
        ld_x = ld_fwd ? start_x : end_x;
        ld_y = ld_fwd ? start_y : end_y;
        if (ld_x_major)
        begin
            ld_end = ld_fwd ? end_x : start_x;
            ld_active = (ld_x < ld_end);
        end
        else
        begin
            ld_end = ld_fwd ? end_y : start_y;
            ld_active = (ld_y < ld_end);
        end
    end

    always_comb
    begin
        st_x = cur_x_reg;
        st_y = cur_y_reg;
        if (x_major_reg)
        begin
            st_keep = err_reg[ERR_BITS-1];
            st_inc_keep = $signed({2'b00, abs_dy_reg, 1'b0});
            st_inc_move = $signed({2'b00, abs_dy_reg, 1'b0})
                          - $signed({2'b00, abs_dx_reg, 1'b0});
            st_x = cur_x_reg + COORD_ONE;
            if (!st_keep)
            begin
                st_y = minor_down_reg ? cur_y_reg - COORD_ONE : cur_y_reg + COORD_ONE;
            end
            st_major = st_x;
        end
        else
        begin
            st_keep = err_reg[ERR_BITS-1] || (err_reg == '0);
            st_inc_keep = $signed({2'b00, abs_dx_reg, 1'b0});
            st_inc_move = $signed({2'b00, abs_dx_reg, 1'b0})
                          - $signed({2'b00, abs_dy_reg, 1'b0});
            st_y = cur_y_reg + COORD_ONE;
            if (!st_keep)
            begin
                st_x = minor_down_reg ? cur_x_reg - COORD_ONE : cur_x_reg + COORD_ONE;
            end
            st_major = st_y;
        end
    end

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        major_end_next = major_end_reg;
        err_next = err_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        x_major_next = x_major_reg;
        minor_down_next = minor_down_reg;
        mod3_next = mod3_reg;
        mod5_next = mod5_reg;
        phase_next = phase_reg;
        active_next = active_reg;
        pix_x = '0;
        pix_y = '0;
        flags = '0;
        if (ctrl.opcode == bsl_pkg::OP_LOAD)
        begin
            cur_x_next = ld_x;
            cur_y_next = ld_y;
            major_end_next = ld_end;
            abs_dx_next = ld_adx;
            abs_dy_next = ld_ady;
            x_major_next = ld_x_major;
            minor_down_next = !((dx[COORD_BITS] && dy[COORD_BITS])
                                || (!dx[COORD_BITS] && dx != '0
                                    && !dy[COORD_BITS] && dy != '0));
            if (ld_x_major)
            begin
                err_next = $signed({2'b00, ld_ady, 1'b0}) - $signed({3'b000, ld_adx});
            end
            else
            begin
                err_next = $signed({2'b00, ld_adx, 1'b0}) - $signed({3'b000, ld_ady});
            end
            mod3_next = '0;
            mod5_next = '0;
            phase_next = '0;
            active_next = ld_active;
            pix_x = ld_x;
            pix_y = ld_y;
            flags.plot = 1'b1;
            flags.last = !ld_active;
            flags.valid_res = 1'b1;
        end
        else if (active_reg)
        begin
            cur_x_next = st_x;
            cur_y_next = st_y;
            err_next = err_reg + (st_keep ? st_inc_keep : st_inc_move);
            mod3_next = (mod3_reg >= bsl_pkg::MOD3_LAST) ? 2'd0 : mod3_reg + 2'd1;
            mod5_next = (mod5_reg >= bsl_pkg::MOD5_LAST) ? 3'd0 : mod5_reg + 3'd1;
            phase_next = (phase_reg >= bsl_pkg::DASHDOT_LAST) ? 4'd0 : phase_reg + 4'd1;
            active_next = (st_major < major_end_reg);
            pix_x = st_x;
            pix_y = st_y;
            flags.plot = bsl_pkg::style_plots(style, mod3_reg, mod5_reg, phase_reg);
            flags.last = !(st_major < major_end_reg);
            flags.valid_res = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            major_end_reg <= '0;
            err_reg <= '0;
            abs_dx_reg <= '0;
            abs_dy_reg <= '0;
            x_major_reg <= 1'b0;
            minor_down_reg <= 1'b0;
            mod3_reg <= '0;
            mod5_reg <= '0;
            phase_reg <= '0;
            active_reg <= 1'b0;
        end
        else if (ctrl.take)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            major_end_reg <= major_end_next;
            err_reg <= err_next;
            abs_dx_reg <= abs_dx_next;
            abs_dy_reg <= abs_dy_next;
            x_major_reg <= x_major_next;
            minor_down_reg <= minor_down_next;
            mod3_reg <= mod3_next;
            mod5_reg <= mod5_next;
            phase_reg <= phase_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== design/bresenham_styled_line_stepper.sv =====
// Top level of the styled line stepper: style register, output register and handshake.
// Throughput: one command and one pixel per cycle unless the output stalls, set by the
// single state update per beat. Each pixel beat is registered when its command is taken.
// The input is ready whenever the output register is empty or being drained.
// Reset clears the line state, pattern counters, style (solid) and the output valid bit.
`include "assert_macros.svh"

module bresenham_styled_line_stepper #(
    parameter int COORD_BITS = bsl_pkg::COORD_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    bsl_in_if.sink     in_ch,
    bsl_out_if.source  out_ch
);

    bsl_pkg::style_t       style_reg;
    bsl_pkg::step_ctrl_t   ctrl;
    logic [COORD_BITS-1:0] pix_x, pix_y;
    bsl_pkg::pixel_flags_t flags;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    bsl_pkg::pixel_flags_t flags_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign ctrl.take = in_ch.valid && in_ch.ready;
    assign ctrl.opcode = in_ch.opcode;

    bsl_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .style   (style_reg),
        .start_x (in_ch.start_x),
        .start_y (in_ch.start_y),
        .end_x   (in_ch.end_x),
        .end_y   (in_ch.end_y),
        .pix_x   (pix_x),
        .pix_y   (pix_y),
        .flags   (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg <= bsl_pkg::STYLE_SOLID;
        end
        else if (cfg_wr_en)
        begin
            style_reg <= bsl_pkg::style_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            pix_x_reg <= pix_x;
            pix_y_reg <= pix_y;
            flags_reg <= flags;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.pixel_x = pix_x_reg;
    assign out_ch.pixel_y = pix_y_reg;
    assign out_ch.plot = flags_reg.plot;
    assign out_ch.last = flags_reg.last;
    assign out_ch.valid_res = flags_reg.valid_res;

    // An accepted command beat always leaves a pixel beat waiting in the next cycle.
    `ASSERT_NEXT(a_take_gives_beat, clk, rst_n, ctrl.take, out_valid_reg, "pixel beat missing after command")
    // A load always produces a plotted, valid start pixel.
    `ASSERT_NEXT(a_load_plots, clk, rst_n, ctrl.take && (in_ch.opcode == bsl_pkg::OP_LOAD), flags_reg.plot && flags_reg.valid_res, "load pixel not plotted")
    // A step with no active line carries an all-zero pixel.
    `ASSERT_SAME(a_idle_zero, clk, rst_n, out_valid_reg && !flags_reg.valid_res, (pix_x_reg == '0) && (pix_y_reg == '0) && !flags_reg.plot && !flags_reg.last, "idle step pixel not zero")

endmodule

// ===== tb/bresenham_styled_line_stepper_test.sv =====
// Self-checking testbench for the styled Bresenham line stepper with a cycle-free pixel predictor.
module bresenham_styled_line_stepper_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 12;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES = 6;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic          opcode;
        logic [CB-1:0] start_x;
        logic [CB-1:0] start_y;
        logic [CB-1:0] end_x;
        logic [CB-1:0] end_y;
    } line_cmd_t;

    typedef struct packed {
        logic [CB-1:0] pixel_x;
        logic [CB-1:0] pixel_y;
        logic          plot;
        logic          last;
        logic          valid_res;
    } pixel_t;

    typedef struct packed {
        line_cmd_t cmd;
        logic      fixed;
        pixel_t    pixel;
    } directed_row_t;

    localparam pixel_t NO_PIXEL = '0;
    localparam line_cmd_t STEP_CMD = '{bsl_pkg::OP_STEP, '0, '0, '0, '0};

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{STEP_CMD, 1'b1, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1,
          '{12'd0, 12'd0, 1'b1, 1'b1, 1'b1}},
        '{STEP_CMD, 1'b1, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{CMAX, CMAX, 1'b1, 1'b1, 1'b1}},
        '{STEP_CMD, 1'b1, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, CMAX, 12'd0, 12'd0, CMAX}, 1'b1,
          '{12'd0, CMAX, 1'b1, 1'b0, 1'b1}},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd0, 12'd0, CMAX, CMAX}, 1'b1,
          '{12'd0, 12'd0, 1'b1, 1'b0, 1'b1}},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd10, 12'd0, 12'd13, 12'd9}, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd5, 12'd5, 12'd0, 12'd5}, 1'b1,
          '{12'd0, 12'd5, 1'b1, 1'b0, 1'b1}},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd3, 12'd7, 12'd3, 12'd0}, 1'b1,
          '{12'd3, 12'd0, 1'b1, 1'b0, 1'b1}},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, CMAX, CMAX, 12'd4093, 12'd4094}, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL},
        '{'{bsl_pkg::OP_LOAD, 12'd100, 12'd200, 12'd98, 12'd205}, 1'b0, NO_PIXEL},
        '{STEP_CMD, 1'b0, NO_PIXEL}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;

    bsl_in_if  #(.COORD_BITS(CB)) in_ch ();
    bsl_out_if #(.COORD_BITS(CB)) out_ch ();

    bresenham_styled_line_stepper #(.COORD_BITS(CB)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    logic [CB-1:0]    trace_x = '0;
    logic [CB-1:0]    trace_y = '0;
    logic [CB-1:0]    trace_end = '0;
    int               trace_err = 0;
    int               span_x = 0;
    int               span_y = 0;
    bit               along_x = 1'b0;
    bit               minor_neg = 1'b0;
    int               dot_count = 0;
    int               dash_count = 0;
    int               dashdot_pos = 0;
    bit               line_active = 1'b0;
    bsl_pkg::style_t  line_style = bsl_pkg::STYLE_SOLID;

    pixel_t pixel_queue [$];
    int     mismatches = 0;
    bit     sender_burst = 1'b0;
    bit     hold_off_req = 1'b0;

    function automatic bit style_draws();
        case (line_style)
            bsl_pkg::STYLE_SOLID:  return 1'b1;
            bsl_pkg::STYLE_DOTTED: return dot_count == 0;
            bsl_pkg::STYLE_DASHED: return dash_count != 0;
            default:               return dashdot_pos == 1
                                          || (dashdot_pos >= 3 && dashdot_pos <= 9);
        endcase
    endfunction

    function automatic pixel_t trace_pixel(line_cmd_t c);
        pixel_t p;
        int     dx;
        int     dy;
        bit     fwd;
        p = '0;
        if (c.opcode == bsl_pkg::OP_LOAD)
        begin
            dx = int'(c.end_x) - int'(c.start_x);
            dy = int'(c.end_y) - int'(c.start_y);
            span_x = dx < 0 ? -dx : dx;
            span_y = dy < 0 ? -dy : dy;
            along_x = span_y <= span_x;
            minor_neg = !((dx < 0 && dy < 0) || (dx > 0 && dy > 0));
            if (along_x)
            begin
                trace_err = 2 * span_y - span_x;
                fwd = dx >= 0;
                trace_end = fwd ? c.end_x : c.start_x;
            end
            else
            begin
                trace_err = 2 * span_x - span_y;
                fwd = dy >= 0;
                trace_end = fwd ? c.end_y : c.start_y;
            end
            trace_x = fwd ? c.start_x : c.end_x;
            trace_y = fwd ? c.start_y : c.end_y;
            dot_count = 0;
            dash_count = 0;
            dashdot_pos = 0;
            line_active = (along_x ? trace_x : trace_y) < trace_end;
            p = '{trace_x, trace_y, 1'b1, !line_active, 1'b1};
        end
        else if (line_active)
        begin
            if (along_x)
            begin
                trace_x = trace_x + CB'(1);
                if (trace_err < 0)
                begin
                    trace_err += 2 * span_y;
                end
                else
                begin
                    trace_y = minor_neg ? trace_y - CB'(1) : trace_y + CB'(1);
                    trace_err += 2 * (span_y - span_x);
                end
            end
            else
            begin
                trace_y = trace_y + CB'(1);
                if (trace_err <= 0)
                begin
                    trace_err += 2 * span_x;
                end
                else
                begin
                    trace_x = minor_neg ? trace_x - CB'(1) : trace_x + CB'(1);
                    trace_err += 2 * (span_x - span_y);
                end
            end
            p.plot = style_draws();
            dot_count = dot_count >= 2 ? 0 : dot_count + 1;
            dash_count = dash_count >= 4 ? 0 : dash_count + 1;
            dashdot_pos = dashdot_pos >= 9 ? 0 : dashdot_pos + 1;
            p.last = (along_x ? trace_x : trace_y) >= trace_end;
            line_active = !p.last;
            p.pixel_x = trace_x;
            p.pixel_y = trace_y;
            p.valid_res = 1'b1;
        end
        return p;
    endfunction

    function automatic logic [CB-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > int'(CMAX))
            return CMAX;
        return v[CB-1:0];
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return int'(CMAX);
            default: return int'($urandom_range(0, int'(CMAX)));
        endcase
    endfunction

    function automatic line_cmd_t random_cmd(logic op);
        line_cmd_t c;
        c.opcode = op;
        c.start_x = CB'($urandom());
        c.start_y = CB'($urandom());
        c.end_x = CB'($urandom());
        c.end_y = CB'($urandom());
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_cmd(input line_cmd_t c, input bit use_fixed, input pixel_t fixed_pixel);
        int     gap;
        pixel_t p;
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= c.opcode;
        in_ch.start_x <= c.start_x;
        in_ch.start_y <= c.start_y;
        in_ch.end_x <= c.end_x;
        in_ch.end_y <= c.end_y;
        do @(posedge clk); while (!in_ch.ready);
        p = trace_pixel(c);
        pixel_queue.push_back(use_fixed ? fixed_pixel : p);
    endtask

    task automatic wait_for_pixels();
        in_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_style(input bsl_pkg::style_t s);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        line_style = s;
    endtask

    task automatic run_random_lines(input int count);
        line_cmd_t c;
        int        sent;
        int        len;
        int        steps;
        int        bx;
        int        by;
        sent = 0;
        while (sent < count)
        begin
            sender_burst = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 9) == 0)
            begin
                send_cmd(random_cmd(1'($urandom_range(0, 1))), 1'b0, NO_PIXEL);
                sent++;
            end
            else
            begin
                c = random_cmd(bsl_pkg::OP_LOAD);
                if ($urandom_range(0, 7) != 0)
                begin
                    bx = pick_base();
                    by = pick_base();
                    c.start_x = clamp_coord(bx);
                    c.start_y = clamp_coord(by);
                    c.end_x = clamp_coord(bx + $urandom_range(0, 48) - 24);
                    c.end_y = clamp_coord(by + $urandom_range(0, 48) - 24);
                end
                send_cmd(c, 1'b0, NO_PIXEL);
                sent++;
                len = span_x > span_y ? span_x : span_y;
                steps = len > 40 ? 40 : len;
                if ($urandom_range(0, 5) == 0)
                    steps = $urandom_range(0, steps);
                for (int i = 0; i < steps && sent < count; i++)
                begin
                    send_cmd(random_cmd(bsl_pkg::OP_STEP), 1'b0, NO_PIXEL);
                    sent++;
                end
                if (steps == len)
                begin
                    repeat ($urandom_range(0, 2))
                        send_cmd(random_cmd(bsl_pkg::OP_STEP), 1'b0, NO_PIXEL);
                end
            end
        end
    endtask

    initial
    begin
        bsl_pkg::style_t phase_style [PHASES];
        phase_style = '{bsl_pkg::STYLE_DASHDOT, bsl_pkg::STYLE_DOTTED, bsl_pkg::STYLE_DASHED,
                        bsl_pkg::STYLE_SOLID, bsl_pkg::STYLE_DASHDOT, bsl_pkg::STYLE_DOTTED};
        phase_style[5] = bsl_pkg::style_t'($urandom_range(0, 3));
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= bsl_pkg::OP_LOAD;
        in_ch.start_x <= '0;
        in_ch.start_y <= '0;
        in_ch.end_x <= '0;
        in_ch.end_y <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].pixel);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_pixels();
            write_style(phase_style[ph]);
            if (ph == 1)
                hold_off_req = 1'b1;
            run_random_lines(RANDOM_ITEMS / PHASES);
        end

        wait_for_pixels();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (hold_off_req)
            begin
                gap = 400;
                hold_off_req = 1'b0;
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.pixel_x, out_ch.pixel_y, out_ch.plot, out_ch.last, out_ch.valid_res};
            if (pixel_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected pixel beat: x=%0d y=%0d plot=%0b last=%0b valid_res=%0b",
                             got.pixel_x, got.pixel_y, got.plot, got.last, got.valid_res);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y
                    || got.plot !== want.plot || got.last !== want.last
                    || got.valid_res !== want.valid_res)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Pixel mismatch: expected x=%0d y=%0d plot=%0b last=%0b vr=%0b,",
                                 want.pixel_x, want.pixel_y, want.plot, want.last,
                                 want.valid_res,
                                 " got x=%0d y=%0d plot=%0b last=%0b vr=%0b",
                                 got.pixel_x, got.pixel_y, got.plot,
                                 got.last, got.valid_res);
                end
            end
        end
    end

endmodule
